>>> sv/biq_pkg.sv
// ----------------------------------------------------------------------------
// biq_pkg: shared constants and helpers for the biquad IIR filter
// Register map, term codes of the multiply-accumulate sequence and the
// default widths of the datapath.
// ----------------------------------------------------------------------------
package biq_pkg;

  // Default datapath sizing
  localparam int SAMPLE_WIDTH    = 16;
  localparam int COEF_FRAC_BITS  = 28;
  localparam int STATE_FRAC_BITS = 16;
  localparam int COEF_WIDTH      = 32;
  localparam int STATE_WIDTH     = 32;

  // Configuration port
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_WIDTH = 5;
  localparam int IDX_WIDTH  = 3;

  localparam logic [IDX_WIDTH-1:0] REG_B0   = 3'd0;
  localparam logic [IDX_WIDTH-1:0] REG_B1   = 3'd1;
  localparam logic [IDX_WIDTH-1:0] REG_B2   = 3'd2;
  localparam logic [IDX_WIDTH-1:0] REG_A0   = 3'd3;
  localparam logic [IDX_WIDTH-1:0] REG_A1   = 3'd4;
  localparam logic [IDX_WIDTH-1:0] REG_A2   = 3'd5;
  localparam logic [IDX_WIDTH-1:0] REG_FORM = 3'd6;

  // Structure select values
  localparam logic FORM_ONE = 1'b0;
  localparam logic FORM_TWO = 1'b1;

  // One product term of the accumulation: coefficient and operand pair
  typedef logic [3:0] term_t;

  localparam term_t T_B0X  = 4'd0;  // b0 * x, sample scaled up
  localparam term_t T_B1X1 = 4'd1;  // b1 * x1, sample scaled up
  localparam term_t T_B2X2 = 4'd2;  // b2 * x2, sample scaled up
  localparam term_t T_A1F1 = 4'd3;  // a1 * f1, subtracted
  localparam term_t T_A2F2 = 4'd4;  // a2 * f2, subtracted
  localparam term_t T_A0X  = 4'd5;  // a0 * x, sample scaled up
  localparam term_t T_B0N  = 4'd6;  // b0 * new state
  localparam term_t T_B1F1 = 4'd7;  // b1 * f1
  localparam term_t T_B2F2 = 4'd8;  // b2 * f2

  typedef logic [2:0] step_t;

  // Number of product terms in a pass
  function automatic step_t n_terms(input logic form);
    n_terms = (form == FORM_ONE) ? 3'd5 : 3'd3;
  endfunction

  // Term issued at a given step of a pass; phase selects the second pass
  // of direct form two (output from the new intermediate value)
  function automatic term_t term_of(input logic form, input logic phase,
                                    input step_t idx);
    term_t t;
    t = T_B0X;
    if (form == FORM_ONE) begin
      case (idx)
        3'd0:    t = T_B0X;
        3'd1:    t = T_B1X1;
        3'd2:    t = T_B2X2;
        3'd3:    t = T_A1F1;
        default: t = T_A2F2;
      endcase
    end else if (!phase) begin
      case (idx)
        3'd0:    t = T_A0X;
        3'd1:    t = T_A1F1;
        default: t = T_A2F2;
      endcase
    end else begin
      case (idx)
        3'd0:    t = T_B0N;
        3'd1:    t = T_B1F1;
        default: t = T_B2F2;
      endcase
    end
    term_of = t;
  endfunction

endpackage

>>> sv/biquad_iir_filter_unit.sv
// ----------------------------------------------------------------------------
// biquad_iir_filter_unit: second-order IIR filter, fixed point
// Direct form one or two biquad with Q4.28 coefficients and Q16.16 state,
// built around one shared 32x32 multiplier and a wide accumulator.
// ----------------------------------------------------------------------------
// One sample goes in, one rounded and saturated sample comes out, along with
// a flag that is set when either the stored state or the output clipped.
// All products are issued one per cycle through a single 32x32 signed
// multiplier and summed in an exact accumulator, so the work per item
// follows the number of terms: five in direct form one, three plus three
// in direct form two, with a rounding step between the two passes. The
// input side stalls from acceptance until the result has been loaded into
// the output register, which waits while the output side stalls, so no new
// item is taken before the last one is through. The user must write the
// coefficients and the form bit through the APB port only while no item is
// in flight; the block does not enforce this. A form switch keeps the
// feedback history as it is.
module biquad_iir_filter_unit #(
  parameter int SAMPLE_WIDTH    = biq_pkg::SAMPLE_WIDTH,
  parameter int COEF_FRAC_BITS  = biq_pkg::COEF_FRAC_BITS,
  parameter int STATE_FRAC_BITS = biq_pkg::STATE_FRAC_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Input channel
  input  logic                                  sample_valid,
  output logic                                  sample_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]        sample_in,
  // Result channel
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic signed [SAMPLE_WIDTH-1:0]        sample_out,
  output logic                                  clipped,
  // Configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [biq_pkg::ADDR_WIDTH-1:0]        paddr,
  input  logic [biq_pkg::DATA_WIDTH-1:0]        pwdata,
  output logic [biq_pkg::DATA_WIDTH-1:0]        prdata,
  output logic                                  pready
);

  localparam int CW = biq_pkg::COEF_WIDTH;
  localparam int SW = biq_pkg::STATE_WIDTH;
  // Widest single term plus headroom for five terms and the sign
  localparam int TERM_BITS = (SAMPLE_WIDTH + STATE_FRAC_BITS + 30 > 62) ?
                             (SAMPLE_WIDTH + STATE_FRAC_BITS + 30) : 62;
  localparam int ACC_W     = TERM_BITS + 4;
  localparam int RS        = COEF_FRAC_BITS;
  localparam int RO        = COEF_FRAC_BITS + STATE_FRAC_BITS;

  localparam logic signed [ACC_W:0] HALF_S  = (ACC_W+1)'(1) << (RS - 1);
  localparam logic signed [ACC_W:0] HALF_O  = (ACC_W+1)'(1) << (RO - 1);
  localparam logic signed [ACC_W:0] ST_MAX  =
    (ACC_W+1)'({1'b0, {(SW-1){1'b1}}});
  localparam logic signed [ACC_W:0] ST_MIN  = -ST_MAX - (ACC_W+1)'(1);
  localparam logic signed [ACC_W:0] OUT_MAX =
    (ACC_W+1)'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
  localparam logic signed [ACC_W:0] OUT_MIN = -OUT_MAX - (ACC_W+1)'(1);
  localparam logic [CW-1:0] COEF_ONE = CW'(1) << COEF_FRAC_BITS;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_MAC     = 3'd1;
  localparam logic [2:0] ST_RND_ST  = 3'd2;
  localparam logic [2:0] ST_RND_OUT = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;

  // Configuration registers
  logic signed [CW-1:0] coef_b0, coef_b1, coef_b2, coef_a0, coef_a1, coef_a2;
  logic                 structure_form;

  // Sequencer
  logic [2:0]           state;
  biq_pkg::step_t       cnt;
  logic                 phase;

  // History and working registers
  logic signed [SAMPLE_WIDTH-1:0] x_cur, x_one, x_two;
  logic signed [SW-1:0]           f_one, f_two, new_st;
  logic signed [SAMPLE_WIDTH-1:0] y_val;
  logic                           sat;

  // Multiplier and accumulator
  logic signed [2*CW-1:0] prod;
  logic                   prod_sub, prod_shift;
  logic signed [ACC_W-1:0] acc;

  logic                   cfg_write;
  logic [biq_pkg::IDX_WIDTH-1:0] cfg_idx;
  logic                   accept;
  logic                   out_free;
  biq_pkg::step_t         n_pass;
  biq_pkg::term_t         term;
  logic signed [CW-1:0]   mul_a, mul_b;
  logic                   term_sub, term_shift;
  logic signed [ACC_W-1:0] addend;
  logic                   rnd_sel;
  logic signed [ACC_W:0]  rnd_t, rnd_q, rnd_max, rnd_min, rnd_val;
  logic                   rnd_sat;

  assign pready       = 1'b1;
  assign cfg_write    = psel && penable && pwrite;
  assign cfg_idx      = paddr[biq_pkg::ADDR_WIDTH-1:2];
  assign sample_stall = (state != ST_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign out_free     = !result_valid || !result_stall;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0        <= COEF_ONE;
      coef_b1        <= '0;
      coef_b2        <= '0;
      coef_a0        <= COEF_ONE;
      coef_a1        <= '0;
      coef_a2        <= '0;
      structure_form <= biq_pkg::FORM_ONE;
    end else if (cfg_write) begin
      case (cfg_idx)
        biq_pkg::REG_B0:   coef_b0        <= pwdata;
        biq_pkg::REG_B1:   coef_b1        <= pwdata;
        biq_pkg::REG_B2:   coef_b2        <= pwdata;
        biq_pkg::REG_A0:   coef_a0        <= pwdata;
        biq_pkg::REG_A1:   coef_a1        <= pwdata;
        biq_pkg::REG_A2:   coef_a2        <= pwdata;
        biq_pkg::REG_FORM: structure_form <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    case (cfg_idx)
      biq_pkg::REG_B0:   prdata = coef_b0;
      biq_pkg::REG_B1:   prdata = coef_b1;
      biq_pkg::REG_B2:   prdata = coef_b2;
      biq_pkg::REG_A0:   prdata = coef_a0;
      biq_pkg::REG_A1:   prdata = coef_a1;
      biq_pkg::REG_A2:   prdata = coef_a2;
      biq_pkg::REG_FORM: prdata = {{(biq_pkg::DATA_WIDTH-1){1'b0}}, structure_form};
      default:           prdata = '0;
    endcase
  end

  // Pick the coefficient and operand of the current term
  assign n_pass = biq_pkg::n_terms(structure_form);
  assign term   = biq_pkg::term_of(structure_form, phase, cnt);

  always_comb begin
    mul_a      = coef_b0;
    mul_b      = CW'(x_cur);
    term_sub   = 1'b0;
    term_shift = 1'b1;
    case (term)
      biq_pkg::T_B0X: begin
        mul_a = coef_b0;
        mul_b = CW'(x_cur);
      end
      biq_pkg::T_B1X1: begin
        mul_a = coef_b1;
        mul_b = CW'(x_one);
      end
      biq_pkg::T_B2X2: begin
        mul_a = coef_b2;
        mul_b = CW'(x_two);
      end
      biq_pkg::T_A1F1: begin
        mul_a      = coef_a1;
        mul_b      = f_one;
        term_sub   = 1'b1;
        term_shift = 1'b0;
      end
      biq_pkg::T_A2F2: begin
        mul_a      = coef_a2;
        mul_b      = f_two;
        term_sub   = 1'b1;
        term_shift = 1'b0;
      end
      biq_pkg::T_A0X: begin
        mul_a = coef_a0;
        mul_b = CW'(x_cur);
      end
      biq_pkg::T_B0N: begin
        mul_a      = coef_b0;
        mul_b      = new_st;
        term_shift = 1'b0;
      end
      biq_pkg::T_B1F1: begin
        mul_a      = coef_b1;
        mul_b      = f_one;
        term_shift = 1'b0;
      end
      biq_pkg::T_B2F2: begin
        mul_a      = coef_b2;
        mul_b      = f_two;
        term_shift = 1'b0;
      end
      default: ;
    endcase
  end

  // Align the registered product to the accumulator fraction point
  assign addend = prod_shift ? (ACC_W'(prod) <<< STATE_FRAC_BITS) : ACC_W'(prod);

  // Round half up and saturate: state width or sample width
  assign rnd_sel = (state == ST_RND_OUT);
  assign rnd_t   = (ACC_W+1)'(acc) + (rnd_sel ? HALF_O : HALF_S);
  assign rnd_q   = rnd_sel ? (rnd_t >>> RO) : (rnd_t >>> RS);
  assign rnd_max = rnd_sel ? OUT_MAX : ST_MAX;
  assign rnd_min = rnd_sel ? OUT_MIN : ST_MIN;

  always_comb begin
    rnd_sat = 1'b0;
    rnd_val = rnd_q;
    if (rnd_q > rnd_max) begin
      rnd_sat = 1'b1;
      rnd_val = rnd_max;
    end else if (rnd_q < rnd_min) begin
      rnd_sat = 1'b1;
      rnd_val = rnd_min;
    end
  end

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      phase        <= 1'b0;
      result_valid <= 1'b0;
      x_one        <= '0;
      x_two        <= '0;
      f_one        <= '0;
      f_two        <= '0;
    end else begin
      // Drop the result once taken; in ST_DONE the load below decides
      if (result_valid && !result_stall && (state != ST_DONE)) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            x_cur <= sample_in;
            acc   <= '0;
            sat   <= 1'b0;
            cnt   <= '0;
            phase <= 1'b0;
            state <= ST_MAC;
          end
        end
        ST_MAC: begin
          // Issue a term while any remain, add the previous product
          if (cnt != n_pass) begin
            prod       <= mul_a * mul_b;
            prod_sub   <= term_sub;
            prod_shift <= term_shift;
          end
          if (cnt != '0) begin
            acc <= prod_sub ? (acc - addend) : (acc + addend);
          end
          if (cnt == n_pass) begin
            cnt   <= '0;
            state <= phase ? ST_RND_OUT : ST_RND_ST;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        ST_RND_ST: begin
          new_st <= rnd_val[SW-1:0];
          if (rnd_sat) begin
            sat <= 1'b1;
          end
          if (structure_form == biq_pkg::FORM_ONE) begin
            state <= ST_RND_OUT;
          end else begin
            // Second pass: output from the new intermediate value
            acc   <= '0;
            phase <= 1'b1;
            state <= ST_MAC;
          end
        end
        ST_RND_OUT: begin
          y_val <= rnd_val[SAMPLE_WIDTH-1:0];
          if (rnd_sat) begin
            sat <= 1'b1;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          // Hold until the output register is free, then advance history
          if (out_free) begin
            sample_out   <= y_val;
            clipped      <= sat;
            result_valid <= 1'b1;
            x_two        <= x_one;
            x_one        <= x_cur;
            f_two        <= f_one;
            f_one        <= new_st;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
